// File: hw/rtl/urpd_pkg.sv
`default_nettype none
// ============================================================================
// urpd_pkg
// Shared types, codes and helpers of the UDP receive port dispatch block.
// ============================================================================
package urpd_pkg;

    localparam int TABLE_SLOTS_DEF = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = 2;
    localparam int SLOT_W          = 3;
    localparam int PADDR_W         = 3;

    localparam logic REG_LOCAL_IP    = 1'b0;
    localparam logic REG_UNREACH_GAP = 1'b1;

    localparam logic [15:0] GAP_RESET       = 16'd33;
    localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [15:0] SUM_ALL_ONES    = 16'hFFFF;
    localparam logic [15:0] UDP_PROTO_NUM   = 16'd17;
    localparam logic [4:0]  ICMP_EMBED_BASE = 5'd20;
    localparam logic [4:0]  ICMP_EMBED_MAX  = 5'd8;
    localparam logic [2:0]  CSUM_LAST_STEP  = 3'd5;

    typedef enum logic [1:0] {
        KIND_BIND   = 2'd0,
        KIND_UNBIND = 2'd1,
        KIND_BYTE   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_BOUND        = 4'd0,
        ST_DUP          = 4'd1,
        ST_FULL         = 4'd2,
        ST_UNBOUND      = 4'd3,
        ST_NOT_FOUND    = 4'd4,
        ST_DELIVERED    = 4'd5,
        ST_MALFORMED    = 4'd6,
        ST_BAD_SOURCE   = 4'd7,
        ST_BAD_CSUM     = 4'd8,
        ST_UNREACHABLE  = 4'd9,
        ST_RATE_LIMITED = 4'd10
    } t_status;

    typedef enum logic [2:0] {
        OP_BIND,
        OP_UNBIND,
        OP_DELIVER,
        OP_MALFORMED,
        OP_BADSRC
    } t_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] src_ip;
        logic [31:0] time_now;
    } t_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  slot;
        logic [15:0] from_port;
        logic [15:0] to_port;
        logic [15:0] payload_len;
        logic [4:0]  reply_len;
    } t_result;

    typedef struct packed {
        t_op         op;
        logic [15:0] port;
        logic [15:0] from_port;
        logic [15:0] length;
        logic        csum_zero;
        logic [16:0] sum;
        logic [31:0] src_ip;
        logic [31:0] time_now;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic [16:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return {1'b0, s[15:0]} + {16'h0000, s[16]};
    endfunction

    function automatic t_result make_result(
        input t_status     status,
        input logic [2:0]  slot,
        input logic [15:0] from_port,
        input logic [15:0] to_port,
        input logic [15:0] payload_len,
        input logic [4:0]  reply_len
    );
        t_result r;
        r.status      = status;
        r.slot        = slot;
        r.from_port   = from_port;
        r.to_port     = to_port;
        r.payload_len = payload_len;
        r.reply_len   = reply_len;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/udp_receive_port_dispatch_top.sv
`default_nettype none
// ============================================================================
// udp_receive_port_dispatch_top
// UDP receive port table, checksum verification and destination dispatch.
//
//  channel  | signals                             | transfer when
//  ---------+-------------------------------------+------------------------------
//  item in  | start, busy, i_item                 | start high, busy low
//  result   | o_strobe, o_result                  | o_strobe high (one cycle)
//  config   | psel, penable, pwrite, paddr, pwdata | psel, penable, pwrite, pready
//
//  Datagram bytes are taken whenever busy is low; busy rises only when the
//  four-entry command queue is full. The back part dequeues a command only
//  while idle; a datagram with a nonzero checksum then runs the checksum
//  states, and a scan covers up to TABLE_SLOTS slots (one slot a cycle).
//  Reset is synchronous: table empty, queue empty, registers at reset values.
//  Results are shown for one cycle and cannot be held off.
// ============================================================================
module udp_receive_port_dispatch_top
    import urpd_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_item              i_item,
    output logic                    o_strobe,
    output t_result                 o_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [31:0] r_local_ip;
    logic [15:0] r_unreach_gap;

    logic   accept;
    logic   push;
    t_cmd   front_cmd;
    t_cmd   queue_cmd;
    logic   pop;
    t_qstat qstat;

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_UNREACH_GAP) ? {16'h0000, r_unreach_gap}
                                                          : r_local_ip;
    assign busy   = qstat.full;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip    <= '0;
            r_unreach_gap <= GAP_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[PADDR_W-1] == REG_LOCAL_IP) begin
                r_local_ip <= pwdata;
            end else begin
                r_unreach_gap <= pwdata[15:0];
            end
        end
    end

    urpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    urpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_qstat (qstat)
    );

    urpd_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_local_ip    (r_local_ip),
        .i_unreach_gap (r_unreach_gap),
        .i_qstat       (qstat),
        .i_cmd         (queue_cmd),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_result      (o_result)
    );

endmodule
`default_nettype wire

// File: hw/rtl/urpd_front.sv
`default_nettype none
// ============================================================================
// urpd_front
// Accepts items, tracks datagram header and running sum, classifies commands.
// ============================================================================
module urpd_front
    import urpd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept,
    input  wire t_item i_item,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [15:0] r_count, n_count;
    logic [15:0] r_src,   n_src;
    logic [15:0] r_dst,   n_dst;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_csum,  n_csum;
    logic [7:0]  r_hold,  n_hold;
    logic [16:0] r_sum,   n_sum;

    logic in_hdr;
    logic odd;
    logic malformed;
    logic bad_src;
    logic [15:0] word;

    always_comb begin
        n_count   = r_count;
        n_src     = r_src;
        n_dst     = r_dst;
        n_len     = r_len;
        n_csum    = r_csum;
        n_hold    = r_hold;
        n_sum     = r_sum;
        o_push    = 1'b0;
        o_cmd     = '0;
        odd       = r_count[0];
        in_hdr    = (r_count < UDP_HDR_BYTES);
        word      = {r_hold, i_item.data_byte};
        malformed = 1'b0;
        bad_src   = 1'b0;
        if (i_accept) begin
            case (i_item.kind)
                KIND_BIND: begin
                    o_push    = 1'b1;
                    o_cmd.op  = OP_BIND;
                    o_cmd.port = i_item.port;
                end
                KIND_UNBIND: begin
                    o_push    = 1'b1;
                    o_cmd.op  = OP_UNBIND;
                    o_cmd.port = i_item.port;
                end
                KIND_BYTE: begin
                    if (in_hdr && !odd) begin
                        n_hold = i_item.data_byte;
                    end
                    if (in_hdr && odd) begin
                        case (r_count[2:1])
                            2'd0:    n_src  = word;
                            2'd1:    n_dst  = word;
                            2'd2:    n_len  = word;
                            default: n_csum = word;
                        endcase
                    end
                    if (in_hdr || (r_count < r_len)) begin
                        n_sum = oc_add(r_sum[15:0], odd ? {8'h00, i_item.data_byte}
                                                        : {i_item.data_byte, 8'h00});
                    end
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 16'd1;
                    end
                    if (i_item.last_byte) begin
                        malformed = (n_count < UDP_HDR_BYTES) || (n_len > n_count) ||
                                    (n_len < UDP_HDR_BYTES);
                        bad_src   = (i_item.src_ip != 32'h0) &&
                                    ((i_item.src_ip == 32'hFFFF_FFFF) ||
                                     (i_item.src_ip[7:4] == 4'hE));
                        o_push          = 1'b1;
                        o_cmd.op        = malformed ? OP_MALFORMED :
                                          bad_src   ? OP_BADSRC    : OP_DELIVER;
                        o_cmd.port      = n_dst;
                        o_cmd.from_port = n_src;
                        o_cmd.length    = n_len;
                        o_cmd.csum_zero = (n_csum == 16'h0000);
                        o_cmd.sum       = n_sum;
                        o_cmd.src_ip    = i_item.src_ip;
                        o_cmd.time_now  = i_item.time_now;
                        n_count = '0;
                        n_src   = '0;
                        n_dst   = '0;
                        n_len   = '0;
                        n_csum  = '0;
                        n_hold  = '0;
                        n_sum   = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_len   <= '0;
            r_csum  <= '0;
            r_hold  <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_len   <= n_len;
            r_csum  <= n_csum;
            r_hold  <= n_hold;
            r_sum   <= n_sum;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/urpd_queue.sv
`default_nettype none
// ============================================================================
// urpd_queue
// Short command queue between the front and back parts.
// ============================================================================
module urpd_queue
    import urpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_qstat    o_qstat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_cmd         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/urpd_back.sv
`default_nettype none
// ============================================================================
// urpd_back
// Executes queued commands: port table scan, checksum finish, verdicts.
// ============================================================================
module urpd_back
    import urpd_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_local_ip,
    input  wire logic [15:0] i_unreach_gap,
    input  wire t_qstat      i_qstat,
    input  wire t_cmd        i_cmd,
    output logic             o_pop,
    output logic             o_strobe,
    output t_result          o_result
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CSUM,
        S_SCAN
    } t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [2:0]       r_step;
    logic [16:0]      r_sum;
    logic [IDX_W-1:0] r_idx;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic [15:0]      r_bound [TABLE_SLOTS];
    logic             r_used  [TABLE_SLOTS];
    logic [31:0]      r_last_unreach;
    logic             r_strobe;
    t_result          r_result;

    logic [15:0]      term;
    logic [16:0]      csum_next;
    logic             hit;
    logic             idx_last;
    logic [IDX_W-1:0] fin_idx;
    logic             fin_free;
    logic [31:0]      since_last;
    logic             too_soon;
    logic [4:0]       reply_len;
    logic [15:0]      payload_len;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [SLOT_W+IDX_W-1:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

    always_comb begin
        case (r_step)
            3'd0:    term = {r_cmd.src_ip[7:0],   r_cmd.src_ip[15:8]};
            3'd1:    term = {r_cmd.src_ip[23:16], r_cmd.src_ip[31:24]};
            3'd2:    term = {i_local_ip[7:0],     i_local_ip[15:8]};
            3'd3:    term = {i_local_ip[23:16],   i_local_ip[31:24]};
            3'd4:    term = UDP_PROTO_NUM;
            default: term = r_cmd.length;
        endcase
    end

    assign csum_next   = oc_add(r_sum[15:0], term);
    assign hit         = r_used[r_idx] && (r_bound[r_idx] == r_cmd.port);
    assign idx_last    = (r_idx == IDX_W'(TABLE_SLOTS - 1));
    assign fin_free    = r_free_found || !r_used[r_idx];
    assign fin_idx     = r_free_found ? r_free_idx : r_idx;
    assign since_last  = r_cmd.time_now - r_last_unreach;
    assign too_soon    = (r_last_unreach != 32'h0) && (since_last < {16'h0000, i_unreach_gap});
    assign reply_len   = ICMP_EMBED_BASE + ((r_cmd.length < UDP_HDR_BYTES) ? r_cmd.length[4:0]
                                                                          : ICMP_EMBED_MAX);
    assign payload_len = r_cmd.length - UDP_HDR_BYTES;
    assign o_pop       = (r_state == S_IDLE) && !i_qstat.empty;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_strobe       <= 1'b0;
            r_last_unreach <= '0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_cmd        <= i_cmd;
                        r_sum        <= i_cmd.sum;
                        r_step       <= '0;
                        r_idx        <= '0;
                        r_free_found <= 1'b0;
                        r_free_idx   <= '0;
                        unique case (i_cmd.op)
                            OP_MALFORMED: begin
                                r_strobe <= 1'b1;
                                r_result <= make_result(ST_MALFORMED, '0, '0, i_cmd.port,
                                                        '0, '0);
                            end
                            OP_BADSRC: begin
                                r_strobe <= 1'b1;
                                r_result <= make_result(ST_BAD_SOURCE, '0, '0, i_cmd.port,
                                                        '0, '0);
                            end
                            OP_DELIVER: begin
                                r_state <= i_cmd.csum_zero ? S_SCAN : S_CSUM;
                            end
                            default: begin
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_CSUM: begin
                    r_sum  <= csum_next;
                    r_step <= r_step + 3'd1;
                    if (r_step == CSUM_LAST_STEP) begin
                        if (csum_next[15:0] == SUM_ALL_ONES) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state  <= S_IDLE;
                            r_strobe <= 1'b1;
                            r_result <= make_result(ST_BAD_CSUM, '0, '0, r_cmd.port, '0, '0);
                        end
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    unique case (r_cmd.op)
                        OP_BIND: begin
                            if (hit) begin
                                r_state  <= S_IDLE;
                                r_strobe <= 1'b1;
                                r_result <= make_result(ST_DUP, '0, '0, '0, '0, '0);
                            end else if (idx_last) begin
                                r_state  <= S_IDLE;
                                r_strobe <= 1'b1;
                                if (fin_free) begin
                                    r_bound[fin_idx] <= r_cmd.port;
                                    r_used[fin_idx]  <= 1'b1;
                                    r_result <= make_result(ST_BOUND, to_slot(fin_idx), '0, '0,
                                                            '0, '0);
                                end else begin
                                    r_result <= make_result(ST_FULL, '0, '0, '0, '0, '0);
                                end
                            end else if (!r_used[r_idx] && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_idx;
                            end
                        end
                        OP_UNBIND: begin
                            if (hit) begin
                                r_used[r_idx] <= 1'b0;
                                r_state       <= S_IDLE;
                                r_strobe      <= 1'b1;
                                r_result <= make_result(ST_UNBOUND, to_slot(r_idx), '0, '0,
                                                        '0, '0);
                            end else if (idx_last) begin
                                r_state  <= S_IDLE;
                                r_strobe <= 1'b1;
                                r_result <= make_result(ST_NOT_FOUND, '0, '0, '0, '0, '0);
                            end
                        end
                        default: begin
                            if (hit) begin
                                r_state  <= S_IDLE;
                                r_strobe <= 1'b1;
                                r_result <= make_result(ST_DELIVERED, to_slot(r_idx),
                                                        r_cmd.from_port, r_cmd.port,
                                                        payload_len, '0);
                            end else if (idx_last) begin
                                r_state  <= S_IDLE;
                                r_strobe <= 1'b1;
                                if (too_soon) begin
                                    r_result <= make_result(ST_RATE_LIMITED, '0, '0, r_cmd.port,
                                                            '0, reply_len);
                                end else begin
                                    r_last_unreach <= r_cmd.time_now;
                                    r_result <= make_result(ST_UNREACHABLE, '0, '0, r_cmd.port,
                                                            '0, reply_len);
                                end
                            end
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: test/dispatch_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// dispatch_checker
// Follows the item, result and register transfers of the UDP receive port
// dispatch block. Keeps its own port table, header capture and checksum
// state, predicts the verdict of every accepted bind, unbind or last datagram
// byte and compares each result with the oldest prediction still waiting.
// ============================================================================
module dispatch_checker
    import urpd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire t_item              i_item,
    input  wire logic               i_strobe,
    input  wire t_result            i_result,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic               i_pready,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [31:0]        i_pwdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    logic [15:0] port_tbl [TABLE_SLOTS_DEF];
    logic        used_tbl [TABLE_SLOTS_DEF];
    logic [15:0] byte_cnt;
    logic [15:0] hdr_sport;
    logic [15:0] hdr_dport;
    logic [15:0] hdr_len;
    logic [15:0] hdr_csum;
    logic [15:0] csum_acc;
    logic [7:0]  hi_byte;
    logic [31:0] unreach_tick;
    logic [31:0] local_ip;
    logic [15:0] unreach_gap;
    t_result     verdict_q [$];
    int          miss_count = 0;

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [15:0] add_address(input logic [15:0] acc, input logic [31:0] ip);
        return fold_add(fold_add(acc, {ip[7:0], ip[15:8]}), {ip[23:16], ip[31:24]});
    endfunction

    function automatic int find_slot(input logic [15:0] port);
        int hit;
        hit = -1;
        for (int i = TABLE_SLOTS_DEF - 1; i >= 0; i--)
            if (used_tbl[i] && port_tbl[i] == port) hit = i;
        return hit;
    endfunction

    function automatic void clear_frame();
        byte_cnt  = '0;
        hdr_sport = '0;
        hdr_dport = '0;
        hdr_len   = '0;
        hdr_csum  = '0;
        hi_byte   = '0;
        csum_acc  = '0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        logic odd;
        odd = byte_cnt[0];
        if (byte_cnt < UDP_HDR_BYTES) begin
            if (!odd) begin
                hi_byte = b;
            end else begin
                case (byte_cnt[2:1])
                    2'd0: hdr_sport = {hi_byte, b};
                    2'd1: hdr_dport = {hi_byte, b};
                    2'd2: hdr_len   = {hi_byte, b};
                    default: hdr_csum = {hi_byte, b};
                endcase
            end
        end
        if (byte_cnt < UDP_HDR_BYTES || byte_cnt < hdr_len)
            csum_acc = fold_add(csum_acc, odd ? {8'h00, b} : {b, 8'h00});
        if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 16'd1;
    endfunction

    function automatic bit predict_verdict(input t_item it, output t_result r);
        int          hit;
        logic [15:0] s;
        logic [31:0] since;
        bit          produced;
        r        = '0;
        produced = 1'b1;
        case (it.kind)
            KIND_BIND: begin
                if (find_slot(it.port) >= 0) begin
                    r.status = ST_DUP;
                end else begin
                    r.status = ST_FULL;
                    hit      = -1;
                    for (int i = TABLE_SLOTS_DEF - 1; i >= 0; i--)
                        if (!used_tbl[i]) hit = i;
                    if (hit >= 0) begin
                        port_tbl[hit] = it.port;
                        used_tbl[hit] = 1'b1;
                        r.status      = ST_BOUND;
                        r.slot        = SLOT_W'(hit);
                    end
                end
            end
            KIND_UNBIND: begin
                hit      = find_slot(it.port);
                r.status = ST_NOT_FOUND;
                if (hit >= 0) begin
                    used_tbl[hit] = 1'b0;
                    r.status      = ST_UNBOUND;
                    r.slot        = SLOT_W'(hit);
                end
            end
            KIND_BYTE: begin
                absorb_byte(it.data_byte);
                if (!it.last_byte) begin
                    produced = 1'b0;
                end else begin
                    r.to_port = hdr_dport;
                    if (byte_cnt < UDP_HDR_BYTES || hdr_len > byte_cnt ||
                        hdr_len < UDP_HDR_BYTES) begin
                        r.status = ST_MALFORMED;
                    end else if (it.src_ip != '0 &&
                                 (it.src_ip == '1 || it.src_ip[7:4] == 4'hE)) begin
                        r.status = ST_BAD_SOURCE;
                    end else begin
                        s = SUM_ALL_ONES;
                        if (hdr_csum != '0) begin
                            s = add_address(csum_acc, it.src_ip);
                            s = add_address(s, local_ip);
                            s = fold_add(s, UDP_PROTO_NUM);
                            s = fold_add(s, hdr_len);
                        end
                        if (s != SUM_ALL_ONES) begin
                            r.status = ST_BAD_CSUM;
                        end else begin
                            hit = find_slot(hdr_dport);
                            if (hit >= 0) begin
                                r.status      = ST_DELIVERED;
                                r.slot        = SLOT_W'(hit);
                                r.from_port   = hdr_sport;
                                r.payload_len = hdr_len - UDP_HDR_BYTES;
                            end else begin
                                r.reply_len = ICMP_EMBED_BASE + ICMP_EMBED_MAX;
                                since       = it.time_now - unreach_tick;
                                if (unreach_tick != '0 && since < {16'd0, unreach_gap}) begin
                                    r.status = ST_RATE_LIMITED;
                                end else begin
                                    unreach_tick = it.time_now;
                                    r.status     = ST_UNREACHABLE;
                                end
                            end
                        end
                    end
                    clear_frame();
                end
            end
            default: produced = 1'b0;
        endcase
        return produced;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS_DEF; i++) used_tbl[i] = 1'b0;
            clear_frame();
            unreach_tick = '0;
            local_ip     = '0;
            unreach_gap  = GAP_RESET;
            verdict_q.delete();
        end else begin
            if (i_strobe) begin
                if (verdict_q.size() == 0) begin
                    miss_count++;
                    if (miss_count <= 10)
                        $display("unexpected result: status %0d slot %0d dport %h",
                                 i_result.status, i_result.slot, i_result.to_port);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_result !== want) begin
                        miss_count++;
                        if (miss_count <= 10) begin
                            $display({"mismatch expected: status %0d slot %0d sport %h ",
                                      "dport %h plen %0d rlen %0d"},
                                     want.status, want.slot, want.from_port, want.to_port,
                                     want.payload_len, want.reply_len);
                            $display({"mismatch actual:   status %0d slot %0d sport %h ",
                                      "dport %h plen %0d rlen %0d"},
                                     i_result.status, i_result.slot, i_result.from_port,
                                     i_result.to_port, i_result.payload_len,
                                     i_result.reply_len);
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[PADDR_W-1:2] == REG_LOCAL_IP) local_ip = i_pwdata;
                else unreach_gap = i_pwdata[15:0];
            end
            if (i_start && !i_busy) begin
                if (predict_verdict(i_item, fresh)) verdict_q.push_back(fresh);
            end
        end
        o_fail_count <= miss_count;
        o_pending    <= verdict_q.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives bind, unbind and datagram byte traffic into the UDP receive port
// dispatch block, mostly with random idle gaps, rewrites the local address and the
// unreachable gap between phases, and reports the checker's verdict.
// ============================================================================
module testbench;
    import urpd_pkg::*;

    localparam int DRAIN_CYCLES = 120;
    localparam int PHASE_ITEMS  = 360;
    localparam int POOL_SIZE    = 12;
    localparam int CSUM_GOOD    = 0;
    localparam int CSUM_NONE    = 1;
    localparam int CSUM_BROKEN  = 2;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    t_item              item_bus = '0;
    logic               result_strobe;
    t_result            result_bus;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    logic [15:0] port_pool [POOL_SIZE];
    logic [7:0]  frame_q [$];
    logic [31:0] frame_src    = '0;
    logic [31:0] cur_local_ip = '0;
    logic [31:0] tick         = '0;
    int          items_sent   = 0;
    bit          gaps_on      = 1'b1;

    always #5 i_clk = ~i_clk;

    udp_receive_port_dispatch_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item_bus),
        .o_strobe (result_strobe),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dispatch_checker i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item_bus),
        .i_strobe     (result_strobe),
        .i_result     (result_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        #10ms;
        $display("status: fail");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [31:0] pick_src();
        logic [31:0] v;
        int          r;
        v = $urandom;
        r = $urandom_range(0, 99);
        if (r < 8) v = '0;
        else if (r < 15) v = '1;
        else if (r < 25) v[7:4] = 4'hE;
        return v;
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(0, 99) < 80) return port_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom);
    endfunction

    task automatic push_item(input t_kind kind, input logic [15:0] port,
                             input logic [7:0] data, input logic last,
                             input logic [31:0] src);
        t_item it;
        int    pause;
        if ($urandom_range(0, 99) == 0) tick = $urandom;
        else tick = tick + $urandom_range(0, 3);
        it.kind      = kind;
        it.port      = port;
        it.data_byte = data;
        it.last_byte = last;
        it.src_ip    = src;
        it.time_now  = tick;
        start    <= 1'b1;
        item_bus <= it;
        do @(posedge i_clk); while (busy);
        if (kind != KIND_NONE) items_sent++;
        pause = gaps_on ? idle_len() : 0;
        if (pause > 0) begin
            start <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    task automatic table_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            push_item(KIND_BIND, pick_port(), 8'($urandom), 1'($urandom), $urandom);
        else if (r < 90)
            push_item(KIND_UNBIND, pick_port(), 8'($urandom), 1'($urandom), $urandom);
        else
            push_item(KIND_NONE, 16'($urandom), 8'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic send_frame(input bit noisy);
        for (int i = 0; i < frame_q.size(); i++) begin
            if (noisy && $urandom_range(0, 99) < 3) table_op();
            push_item(KIND_BYTE, 16'($urandom), frame_q[i], i == frame_q.size() - 1,
                      frame_src);
        end
    endtask

    task automatic build_frame(input logic [15:0] len_field, input int body, input int extra,
                               input int csum_mode, input logic [15:0] dst);
        logic [15:0] sport;
        logic [15:0] csum;
        logic [31:0] acc;
        int          covered;
        int          r;
        r = $urandom_range(0, 99);
        sport = (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom);
        frame_q.delete();
        frame_q.push_back(sport[15:8]);
        frame_q.push_back(sport[7:0]);
        frame_q.push_back(dst[15:8]);
        frame_q.push_back(dst[7:0]);
        frame_q.push_back(len_field[15:8]);
        frame_q.push_back(len_field[7:0]);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        for (int i = 0; i < body + extra; i++) frame_q.push_back(8'($urandom));
        covered = (len_field < frame_q.size()) ? int'(len_field) : frame_q.size();
        acc = '0;
        for (int i = 0; i < covered; i += 2)
            acc += {16'd0, frame_q[i], (i + 1 < covered) ? frame_q[i + 1] : 8'h00};
        acc += {16'd0, frame_src[7:0], frame_src[15:8]};
        acc += {16'd0, frame_src[23:16], frame_src[31:24]};
        acc += {16'd0, cur_local_ip[7:0], cur_local_ip[15:8]};
        acc += {16'd0, cur_local_ip[23:16], cur_local_ip[31:24]};
        acc += {16'd0, UDP_PROTO_NUM} + {16'd0, len_field};
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        csum = ~acc[15:0];
        if (csum == 16'h0000) csum = 16'hFFFF;
        if (csum_mode == CSUM_NONE) csum = 16'h0000;
        else if (csum_mode == CSUM_BROKEN) csum ^= 16'($urandom_range(1, 65535));
        frame_q[6] = csum[15:8];
        frame_q[7] = csum[7:0];
    endtask

    task automatic random_datagram();
        int          r;
        int          body;
        int          mode;
        int          keep;
        logic [15:0] len;
        logic [15:0] dst;
        frame_src = pick_src();
        if ($urandom_range(0, 99) < 8) begin
            frame_q.delete();
            repeat ($urandom_range(1, 14)) frame_q.push_back(8'($urandom));
        end else begin
            body = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 80);
            len  = 16'(body) + UDP_HDR_BYTES;
            dst  = ($urandom_range(0, 99) < 70) ? port_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : 16'($urandom);
            r    = $urandom_range(0, 99);
            mode = (r < 15) ? CSUM_NONE : (r < 27) ? CSUM_BROKEN : CSUM_GOOD;
            r    = $urandom_range(0, 99);
            if (r < 8) begin
                build_frame(len + 16'($urandom_range(1, 20)), body, 0, mode, dst);
            end else if (r < 14) begin
                build_frame(16'($urandom_range(0, 7)), body, 0, mode, dst);
            end else if (r < 18) begin
                build_frame(len, body, 0, mode, dst);
                keep = $urandom_range(1, 7);
                while (frame_q.size() > keep) void'(frame_q.pop_back());
            end else begin
                build_frame(len, body,
                            ($urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0, mode, dst);
            end
        end
        send_frame(1'b1);
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] ip, input logic [15:0] gap);
        settle();
        reg_write(REG_LOCAL_IP, ip);
        reg_write(REG_UNREACH_GAP, {16'd0, gap});
        cur_local_ip = ip;
    endtask

    task automatic run_phase(input logic [31:0] ip, input logic [15:0] gap, input bit gaps);
        int target;
        configure(ip, gap);
        gaps_on = gaps;
        target  = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 25) table_op();
            else random_datagram();
        end
    endtask

    initial begin : stimulus
        for (int k = 0; k < POOL_SIZE; k++) port_pool[k] = 16'($urandom);
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure($urandom, GAP_RESET);
        push_item(KIND_NONE, 16'($urandom), 8'($urandom), 1'b1, $urandom);
        push_item(KIND_BIND, port_pool[0], 8'h00, 1'b0, '0);
        push_item(KIND_BIND, port_pool[1], 8'hFF, 1'b1, '1);
        push_item(KIND_BIND, port_pool[1], 8'($urandom), 1'b0, $urandom);
        for (int k = 2; k < 8; k++)
            push_item(KIND_BIND, port_pool[k], 8'($urandom), 1'($urandom), $urandom);
        push_item(KIND_BIND, port_pool[8], 8'($urandom), 1'($urandom), $urandom);
        push_item(KIND_UNBIND, port_pool[0], 8'($urandom), 1'($urandom), $urandom);
        push_item(KIND_UNBIND, port_pool[0], 8'($urandom), 1'($urandom), $urandom);
        frame_src = $urandom;
        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame(1'b0);
        frame_src = '0;
        build_frame(UDP_HDR_BYTES, 0, 0, CSUM_NONE, port_pool[1]);
        send_frame(1'b0);

        run_phase($urandom, GAP_RESET, 1'b1);
        run_phase('0, '0, 1'b1);
        run_phase('1, 16'hFFFF, 1'b1);

        configure($urandom, GAP_RESET);
        gaps_on = 1'b0;
        for (int k = 0; k < POOL_SIZE; k++)
            push_item(KIND_UNBIND, port_pool[k], 8'($urandom), 1'($urandom), $urandom);
        push_item(KIND_BIND, port_pool[2], 8'($urandom), 1'($urandom), $urandom);
        frame_src = $urandom & 32'hFFFF_FF7F;
        build_frame(UDP_HDR_BYTES + 16'd200, 200, 65, CSUM_GOOD, port_pool[2]);
        send_frame(1'b0);

        run_phase($urandom, 16'($urandom_range(1, 200)), 1'b0);
        run_phase($urandom, 16'($urandom), 1'b1);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
